### sv/huffman_tree_build_and_decode_top_defines.svh
// Assertion macros for the Huffman tree build and decode block
`ifndef HUFFMAN_TREE_BUILD_AND_DECODE_TOP_DEFINES_SVH
`define HUFFMAN_TREE_BUILD_AND_DECODE_TOP_DEFINES_SVH

// Implication into the next cycle, off while reset is asserted
`define HTBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// Implication into the next cycle, checked during reset as well
`define HTBD_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

### sv/htbd_pkg.sv
// Types and constants shared by the Huffman tree build and decode block
package htbd_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int WEIGHT_BITS = 24;
    localparam int IDX_W       = 9;
    localparam int NODE_DEPTH  = 512;
    localparam int NU_W        = 10;
    localparam int BITS_W      = 4;

    localparam logic [IDX_W-1:0] NIL_NODE   = 9'h1FF;
    localparam logic [NU_W-1:0]  NODE_LIMIT = 10'd511;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_CODE  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_symbol;
        logic [15:0] entry_count;
        logic       entry_last;
        logic [7:0] code_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_of_byte;
        logic       all_done;
    } out_t;

    typedef struct packed {
        logic [IDX_W-1:0]       left;
        logic [IDX_W-1:0]       right;
        logic                   leaf;
        logic [7:0]             sym;
        logic [WEIGHT_BITS-1:0] weight;
    } node_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        node_t            wdata;
        logic [IDX_W-1:0] raddr;
    } node_req_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } link_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_IGNORE,
        ST_ENT_PREV,
        ST_B_START,
        ST_B_L1,
        ST_B_L2,
        ST_B_W2,
        ST_B_WH,
        ST_B_WALK_L,
        ST_B_WALK_W,
        ST_B_INS,
        ST_B_INS2,
        ST_B_FIN,
        ST_D_BIT,
        ST_D_READ,
        ST_D_FLUSH
    } state_t;

endpackage

### sv/huffman_tree_build_and_decode_top.sv
// Top level of the static Huffman tree build and decode block
// Usage:
//  s_ channel: one transaction per dictionary entry (kind = 0) or code byte
//  (kind = 1). Entries arrive in ascending count order; the entry flagged
//  entry_last starts the tree build. An entry after a build starts a new
//  dictionary.
//  m_ channel: one transaction per decoded symbol, last_of_byte on the final
//  symbol of a code byte, all_done once the decoded count hits the root weight.
// Sequence:
//  An entry is written, then chained to the previous leaf. Each merge of the
//  build reads the two lightest nodes and reinserts the parent by a list walk.
//  A code byte is accepted; each bit then either moves nothing or takes a tree
//  step (the node memory read in the walk); after the end of bits the pending
//  symbol is flushed.
//  Results leave through a one-deep output register, so a new item is
//  accepted while the last symbol of a byte still waits on m_ready.
// Reset: synchronous, active low; clears the sequencer, dictionary count and
//  output register. Node memories are not cleared; only written nodes are read.
// Stall: when m_ready is low with a symbol pending, the walk holds until the
//  output register frees up; nothing is dropped.
module huffman_tree_build_and_decode_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  htbd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output htbd_pkg::out_t m_data
);
    import htbd_pkg::*;

    node_req_t  node_req;
    node_t      node_rdata;
    link_req_t  link_req;
    logic [IDX_W-1:0] link_rdata;
    logic [$bits(node_t)-1:0] node_rd_bits;
    logic       push;
    out_t       push_data;
    logic       out_free;

    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;

    // node record store: children, leaf flag, symbol, weight
    htbd_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_DEPTH)) u_node_ram (
        .aclk  (aclk),
        .we    (node_req.we),
        .waddr (node_req.waddr),
        .wdata (node_req.wdata),
        .raddr (node_req.raddr),
        .rdata (node_rd_bits)
    );
    assign node_rdata = node_t'(node_rd_bits);

    // sorted-list links used while building the tree
    htbd_ram #(.WIDTH(IDX_W), .DEPTH(NODE_DEPTH)) u_link_ram (
        .aclk  (aclk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    htbd_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .node_req   (node_req),
        .node_rdata (node_rdata),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .out_free   (out_free),
        .push       (push),
        .push_data  (push_data)
    );

    // output register; push only lands when it is empty
    assign out_free = !m_valid_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

### sv/htbd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read
module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### sv/htbd_ctrl.sv
// Sequencer: dictionary load, tree build and bit-by-bit tree walk
module htbd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  htbd_pkg::in_t      s_data,
    output htbd_pkg::node_req_t node_req,
    input  htbd_pkg::node_t    node_rdata,
    output htbd_pkg::link_req_t link_req,
    input  logic [8:0]         link_rdata,
    input  logic               out_free,
    output logic               push,
    output htbd_pkg::out_t     push_data
);
    import htbd_pkg::*;

    state_t state_reg, state_next;
    logic [NU_W-1:0]        nu_reg, nu_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [IDX_W-1:0]       v2_reg, v2_next;
    logic [IDX_W-1:0]       nh_reg, nh_next;
    logic [IDX_W-1:0]       r_reg, r_next;
    logic [IDX_W-1:0]       lr_reg, lr_next;
    logic [IDX_W-1:0]       nxt_reg, nxt_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [WEIGHT_BITS-1:0] w1_reg, w1_next;
    logic [WEIGHT_BITS-1:0] sum_reg, sum_next;
    logic [WEIGHT_BITS-1:0] root_w_reg, root_w_next;
    logic [WEIGHT_BITS-1:0] total_reg, total_next;
    node_t                  root_node_reg, root_node_next;
    node_t                  cur_reg, cur_next;
    logic                   ready_reg, ready_next;
    logic                   ent_wr_reg, ent_wr_next;
    logic                   ent_last_reg, ent_last_next;
    logic [7:0]             byte_reg, byte_next;
    logic [BITS_W-1:0]      bits_reg, bits_next;
    logic                   pend_reg, pend_next;
    logic [7:0]             pend_sym_reg, pend_sym_next;
    logic                   pend_done_reg, pend_done_next;

    logic [WEIGHT_BITS:0]   sum_wide;
    logic [IDX_W-1:0]       child;
    logic [NU_W-1:0]        nu_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            nu_reg     <= '0;
            head_reg   <= '0;
            total_reg  <= '0;
            ready_reg  <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            nu_reg     <= nu_next;
            head_reg   <= head_next;
            total_reg  <= total_next;
            ready_reg  <= ready_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg         <= p_next;
        v2_reg        <= v2_next;
        nh_reg        <= nh_next;
        r_reg         <= r_next;
        lr_reg        <= lr_next;
        nxt_reg       <= nxt_next;
        n_reg         <= n_next;
        w1_reg        <= w1_next;
        sum_reg       <= sum_next;
        root_w_reg    <= root_w_next;
        root_node_reg <= root_node_next;
        cur_reg       <= cur_next;
        ent_wr_reg    <= ent_wr_next;
        ent_last_reg  <= ent_last_next;
        byte_reg      <= byte_next;
        bits_reg      <= bits_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
    end

    assign sum_wide = {1'b0, w1_reg} + {1'b0, node_rdata.weight};
    assign child    = byte_reg[7] ? cur_reg.right : cur_reg.left;
    assign nu_eff   = ready_reg ? '0 : nu_reg;

    always_comb begin
        state_next     = state_reg;
        nu_next        = nu_reg;
        head_next      = head_reg;
        p_next         = p_reg;
        v2_next        = v2_reg;
        nh_next        = nh_reg;
        r_next         = r_reg;
        lr_next        = lr_reg;
        nxt_next       = nxt_reg;
        n_next         = n_reg;
        w1_next        = w1_reg;
        sum_next       = sum_reg;
        root_w_next    = root_w_reg;
        root_node_next = root_node_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        ready_next     = ready_reg;
        ent_wr_next    = ent_wr_reg;
        ent_last_next  = ent_last_reg;
        byte_next      = byte_reg;
        bits_next      = bits_reg;
        pend_next      = pend_reg;
        pend_sym_next  = pend_sym_reg;
        pend_done_next = pend_done_reg;
        s_ready        = 1'b0;
        node_req       = '0;
        link_req       = '0;
        push           = 1'b0;
        push_data      = '{symbol: pend_sym_reg, last_of_byte: 1'b0, all_done: pend_done_reg};

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.kind == KIND_ENTRY) begin
                        if (ready_reg) begin
                            ready_next = 1'b0;
                            total_next = '0;
                            head_next  = '0;
                        end
                        ent_last_next = s_data.entry_last;
                        ent_wr_next   = (nu_eff < NU_W'(MAX_SYMBOLS));
                        n_next        = nu_eff[IDX_W-1:0];
                        nu_next       = nu_eff;
                        if (nu_eff < NU_W'(MAX_SYMBOLS)) begin
                            node_req.we    = 1'b1;
                            node_req.waddr = nu_eff[IDX_W-1:0];
                            node_req.wdata = '{left: NIL_NODE, right: NIL_NODE, leaf: 1'b1,
                                               sym: s_data.entry_symbol,
                                               weight: WEIGHT_BITS'(s_data.entry_count)};
                            link_req.we    = 1'b1;
                            link_req.waddr = nu_eff[IDX_W-1:0];
                            link_req.wdata = NIL_NODE;
                            nu_next        = nu_eff + 1'b1;
                        end
                        state_next = ST_ENT_PREV;
                    end else if (!ready_reg) begin
                        state_next = ST_IGNORE;
                    end else begin
                        byte_next  = s_data.code_byte;
                        bits_next  = BITS_W'(8);
                        state_next = ST_D_BIT;
                    end
                end
            end
            ST_IGNORE: state_next = ST_IDLE;
            ST_ENT_PREV: begin
                // chain the previous leaf to the new one
                if (ent_wr_reg && n_reg != '0) begin
                    link_req.we    = 1'b1;
                    link_req.waddr = n_reg - 1'b1;
                    link_req.wdata = n_reg;
                end
                if (ent_last_reg && nu_reg != '0) begin
                    head_next  = '0;
                    state_next = ST_B_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_B_START: begin
                link_req.raddr = head_reg;
                state_next     = ST_B_L1;
            end
            ST_B_L1: begin
                node_req.raddr = head_reg;
                if (link_rdata == NIL_NODE || nu_reg >= NODE_LIMIT) begin
                    state_next = ST_B_FIN;
                end else begin
                    v2_next        = link_rdata;
                    link_req.raddr = link_rdata;
                    state_next     = ST_B_L2;
                end
            end
            ST_B_L2: begin
                nh_next        = link_rdata;
                w1_next        = node_rdata.weight;
                node_req.raddr = v2_reg;
                state_next     = ST_B_W2;
            end
            ST_B_W2: begin
                sum_next = sum_wide[WEIGHT_BITS] ? '1 : sum_wide[WEIGHT_BITS-1:0];
                node_req.we    = 1'b1;
                node_req.waddr = nu_reg[IDX_W-1:0];
                node_req.wdata = '{left: head_reg, right: v2_reg, leaf: 1'b0, sym: 8'd0,
                                   weight: sum_next};
                p_next  = nu_reg[IDX_W-1:0];
                nu_next = nu_reg + 1'b1;
                if (nh_reg == NIL_NODE) begin
                    link_req.we    = 1'b1;
                    link_req.waddr = nu_reg[IDX_W-1:0];
                    link_req.wdata = NIL_NODE;
                    head_next      = nu_reg[IDX_W-1:0];
                    state_next     = ST_B_START;
                end else begin
                    node_req.raddr = nh_reg;
                    state_next     = ST_B_WH;
                end
            end
            ST_B_WH: begin
                if (sum_reg <= node_rdata.weight) begin
                    link_req.we    = 1'b1;
                    link_req.waddr = p_reg;
                    link_req.wdata = nh_reg;
                    head_next      = p_reg;
                    state_next     = ST_B_START;
                end else begin
                    r_next         = nh_reg;
                    link_req.raddr = nh_reg;
                    state_next     = ST_B_WALK_L;
                end
            end
            ST_B_WALK_L: begin
                lr_next = link_rdata;
                if (link_rdata == NIL_NODE) begin
                    state_next = ST_B_INS;
                end else begin
                    node_req.raddr = link_rdata;
                    state_next     = ST_B_WALK_W;
                end
            end
            ST_B_WALK_W: begin
                if (sum_reg > node_rdata.weight) begin
                    r_next         = lr_reg;
                    link_req.raddr = lr_reg;
                    state_next     = ST_B_WALK_L;
                end else begin
                    state_next = ST_B_INS;
                end
            end
            ST_B_INS: begin
                link_req.we    = 1'b1;
                link_req.waddr = p_reg;
                link_req.wdata = lr_reg;
                state_next     = ST_B_INS2;
            end
            ST_B_INS2: begin
                link_req.we    = 1'b1;
                link_req.waddr = r_reg;
                link_req.wdata = p_reg;
                head_next      = nh_reg;
                state_next     = ST_B_START;
            end
            ST_B_FIN: begin
                root_node_next = node_rdata;
                cur_next       = node_rdata;
                root_w_next    = node_rdata.weight;
                total_next     = '0;
                ready_next     = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_D_BIT: begin
                if (bits_reg == '0 || total_reg >= root_w_reg) begin
                    state_next = ST_D_FLUSH;
                end else begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    bits_next = bits_reg - 1'b1;
                    if (!cur_reg.leaf && child != NIL_NODE) begin
                        nxt_next       = child;
                        node_req.raddr = child;
                        state_next     = ST_D_READ;
                    end
                end
            end
            ST_D_READ: begin
                node_req.raddr = nxt_reg;
                if (!node_rdata.leaf) begin
                    cur_next   = node_rdata;
                    state_next = ST_D_BIT;
                end else if (!pend_reg || out_free) begin
                    push           = pend_reg;
                    pend_next      = 1'b1;
                    pend_sym_next  = node_rdata.sym;
                    pend_done_next = (total_reg + 1'b1 == root_w_reg);
                    total_next     = total_reg + 1'b1;
                    cur_next       = root_node_reg;
                    state_next     = ST_D_BIT;
                end
            end
            ST_D_FLUSH: begin
                push_data.last_of_byte = 1'b1;
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push       = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

### sv/htbd_checker.sv
// Port-level checks for the Huffman tree build and decode block, with bind
`include "huffman_tree_build_and_decode_top_defines.svh"

module htbd_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready
);
    `HTBD_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")
    `HTBD_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid, "m_valid high after reset")
    `HTBD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "s_ready high right after accept")
endmodule

bind huffman_tree_build_and_decode_top htbd_checker u_htbd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

### dv/huffman_tree_build_and_decode_top_tb.sv
// Testbench for the Huffman tree build and decode block: builds trees, decodes random codes
`timescale 1ns / 1ps

module huffman_tree_build_and_decode_top_tb;
    import htbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 40;

    // Behavioral model of the decoder: its own copy of the node store.
    class symbol_scoreboard;
        logic [IDX_W-1:0]       lch [NODE_DEPTH];
        logic [IDX_W-1:0]       rch [NODE_DEPTH];
        logic                   leaf_f [NODE_DEPTH];
        logic [7:0]             sym_f [NODE_DEPTH];
        logic [WEIGHT_BITS:0]   wt [NODE_DEPTH];
        logic [IDX_W-1:0]       nxt [NODE_DEPTH];
        logic [IDX_W-1:0]       head_q, root_q, pos_q;
        int                     used;
        logic [WEIGHT_BITS-1:0] total;
        bit                     ready_f;
        out_t                   pending_syms[$];
        int                     mismatches;

        function new();
            head_q = '0; root_q = '0; pos_q = '0; used = 0; total = '0; ready_f = 1'b0;
            mismatches = 0;
        endfunction

        function void build_tree();
            logic [IDX_W-1:0] h, v1, v2, p, r;
            logic [WEIGHT_BITS:0] sum;
            int guard;
            h = head_q;
            for (guard = 0; guard < NODE_DEPTH; guard++) begin
                v1 = h;
                v2 = nxt[v1];
                if (v2 == NIL_NODE || used >= NIL_NODE) break;
                h = nxt[v2];
                p = used[IDX_W-1:0];
                used++;
                sum = wt[v1] + wt[v2];
                if (sum > {1'b0, {WEIGHT_BITS{1'b1}}}) sum = {1'b0, {WEIGHT_BITS{1'b1}}};
                lch[p] = v1; rch[p] = v2; leaf_f[p] = 1'b0; sym_f[p] = '0; wt[p] = sum;
                if (h == NIL_NODE || sum <= wt[h]) begin
                    nxt[p] = h;
                    h = p;
                end else begin
                    r = h;
                    while (nxt[r] != NIL_NODE && sum > wt[nxt[r]]) r = nxt[r];
                    nxt[p] = nxt[r];
                    nxt[r] = p;
                end
            end
            head_q = h; root_q = h; pos_q = h; total = '0; ready_f = 1'b1;
        endfunction

        // Note one accepted input transaction and queue the symbols it decodes.
        function void note_input(in_t t);
            logic [IDX_W-1:0] w, n, u;
            logic [WEIGHT_BITS-1:0] root_w;
            out_t o;
            int b, first;
            if (t.kind == KIND_ENTRY) begin
                if (ready_f) begin
                    ready_f = 1'b0; used = 0; head_q = '0; root_q = '0; pos_q = '0;
                    total = '0;
                end
                if (used < MAX_SYMBOLS) begin
                    u = used[IDX_W-1:0];
                    lch[u] = NIL_NODE; rch[u] = NIL_NODE; leaf_f[u] = 1'b1;
                    sym_f[u] = t.entry_symbol; wt[u] = (WEIGHT_BITS+1)'(t.entry_count);
                    nxt[u] = NIL_NODE;
                    if (u == '0) head_q = '0;
                    else nxt[u - 1'b1] = u;
                    used++;
                end
                if (t.entry_last && used > 0) build_tree();
                return;
            end
            if (!ready_f) return;
            first = pending_syms.size();
            root_w = wt[root_q][WEIGHT_BITS-1:0];
            for (b = 7; b >= 0; b--) begin
                w = pos_q;
                if (total >= root_w) break;
                if (leaf_f[w]) continue;
                n = t.code_byte[b] ? rch[w] : lch[w];
                if (n == NIL_NODE) continue;
                pos_q = n;
                if (leaf_f[n]) begin
                    total++;
                    o.symbol = sym_f[n];
                    o.last_of_byte = 1'b0;
                    o.all_done = (total == root_w);
                    pending_syms.push_back(o);
                    pos_q = root_q;
                end
            end
            if (pending_syms.size() > first)
                pending_syms[pending_syms.size()-1].last_of_byte = 1'b1;
        endfunction

        function void check_symbol(out_t got);
            out_t exp_o;
            if (pending_syms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected symbol %p", got);
                return;
            end
            exp_o = pending_syms.pop_front();
            if (got !== exp_o) begin
                mismatches++;
                if (mismatches <= 10) $display("symbol mismatch: expected %p got %p", exp_o, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_data;

    symbol_scoreboard sb = new();
    int idle_cycles = 0;
    bit stim_done = 0;
    bit sink_quiet = 0;   // a phase with the sink always ready

    always #10 aclk = ~aclk;

    huffman_tree_build_and_decode_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if (sink_quiet) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // Scoreboard sees both channels on the same edge the DUT does.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_symbol(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: nothing moved for too long.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sink: random back-pressure.
    initial begin
        int g;
        @(posedge aclk);
        while (1) begin
            g = gap_len();
            if (g > 0) begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    // Send one transaction, holding valid until accepted; optional gap after.
    task automatic send_item(in_t t);
        int g;
        s_valid <= 1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_entry(logic [7:0] sym, logic [15:0] cnt, logic last);
        in_t t;
        t = '0;
        t.kind = KIND_ENTRY; t.entry_symbol = sym; t.entry_count = cnt; t.entry_last = last;
        t.code_byte = 8'($urandom());
        send_item(t);
    endtask

    task automatic send_code(logic [7:0] code);
        in_t t;
        t = '0;
        t.kind = KIND_CODE; t.code_byte = code;
        t.entry_symbol = 8'($urandom()); t.entry_count = 16'($urandom());
        t.entry_last = 1'($urandom());
        send_item(t);
    endtask

    // Ascending dictionary of n entries with random symbols, counts rising by up to cmax each step.
    task automatic send_dictionary(int n, int cmax);
        int c, k;
        c = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
            send_entry(8'($urandom()), c[15:0], k == n - 1);
            c = c + $urandom_range(0, cmax);
            if (c > 65535) c = 65535;
        end
    endtask

    initial begin
        int sent, k, nb, wait_cnt;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: code before any tree, extremes of the fields.
        send_code(8'hFF);
        send_entry(8'h00, 16'd1, 0);
        send_entry(8'hFF, 16'd1, 0);
        send_entry(8'hA5, 16'd2, 1);
        send_code(8'h00); send_code(8'hFF); send_code(8'h5A);
        // One-entry dictionary: nothing decodes.
        send_entry(8'h11, 16'hFFFF, 1);
        send_code(8'hAA);
        // Zero root weight.
        send_entry(8'h22, 16'd0, 0);
        send_entry(8'h33, 16'd0, 1);
        send_code(8'h0F);
        // Large weights, all at the largest entry count.
        send_entry(8'h44, 16'hFFFF, 0);
        send_entry(8'h55, 16'hFFFF, 0);
        send_entry(8'h66, 16'hFFFF, 1);
        send_code(8'hC3); send_code(8'h3C);

        // Random phases: each a dictionary then code bytes.
        sent = 17;
        while (sent < 170) begin
            sink_quiet = ($urandom_range(0, 5) == 0);
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 10);
            send_dictionary(k, ($urandom_range(0, 3) == 0) ? 40000 : 5);
            sent += k;
            nb = $urandom_range(3, 12);
            repeat (nb) send_code(8'($urandom()));
            sent += nb;
        end
        sink_quiet = 0;
        s_valid <= 0;

        wait_cnt = 0;
        while (sb.pending_syms.size() != 0 && wait_cnt < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_syms.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
